// ===== rtl/ray_front_to_back_compositor_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the front-to-back compositor
// Shared property forms, clocked on the rising edge, muted while in reset.
// ----------------------------------------------------------------------------
`ifndef RAY_FRONT_TO_BACK_COMPOSITOR_DEFINES_SVH
`define RAY_FRONT_TO_BACK_COMPOSITOR_DEFINES_SVH

// same-cycle implication
`define RFBC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rfbc: same-cycle property failed");

// next-cycle implication
`define RFBC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rfbc: next-cycle property failed");

`endif

// ===== rtl/rfbc_pkg.sv =====
// ----------------------------------------------------------------------------
// rfbc_pkg
// Types, constants and arithmetic helpers of the front-to-back compositor.
// ----------------------------------------------------------------------------
`default_nettype none

package rfbc_pkg;

  localparam int ADDR_W      = 12;   // widest table index (4096 entries)
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [12:0] ONE_Q12 = 13'd4096;
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // config register indexes
  localparam logic [1:0] CFG_SCALE = 2'd0;
  localparam logic [1:0] CFG_FLOOR = 2'd1;
  localparam logic [1:0] CFG_TERM  = 2'd2;

  localparam logic [15:0] SCALE_RST = 16'd5222;
  localparam logic [12:0] FLOOR_RST = 13'd1;
  localparam logic [16:0] TERM_RST  = 17'd64881;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_LOAD,
    OP_SKIP,
    OP_SHADE
  } q_op_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOOKUP,
    BK_BLEND,
    BK_EMIT
  } bk_state_e;

  typedef struct packed {
    logic               command;
    logic [7:0]         table_index;
    logic [12:0]        table_red;
    logic [12:0]        table_green;
    logic [12:0]        table_blue;
    logic [12:0]        table_opacity;
    logic               sample_inside;
    logic signed [23:0] sample_value;
    logic               last_sample;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic [7:0] pixel_alpha;
    logic       stopped_early;
  } out_item_t;

  typedef struct packed {
    logic [12:0] r;
    logic [12:0] g;
    logic [12:0] b;
    logic [12:0] a;
  } tf_entry_t;

  // one classified item between front and back
  typedef struct packed {
    q_op_e             op;
    logic [ADDR_W-1:0] addr;
    tf_entry_t         rgba;
    logic              last;
  } q_item_t;

  function automatic logic [12:0] sat_q12(input logic [12:0] v);
    sat_q12 = (v > ONE_Q12) ? ONE_Q12 : v;
  endfunction

  // weight = (a * (1 - acc_alpha) + half) >> 12, Q1.16
  function automatic logic [16:0] blend_weight(input logic [12:0] a,
                                               input logic [16:0] acc_a);
    logic [16:0] inv;
    logic [29:0] prod;
    inv  = ONE_Q16 - acc_a;
    prod = {17'd0, a} * {13'd0, inv} + 30'd2048;
    blend_weight = prod[28:12];
  endfunction

  // acc + ((c * w + half) >> 12), saturated at 1.0
  function automatic logic [16:0] add_sat(input logic [16:0] acc,
                                          input logic [12:0] c,
                                          input logic [16:0] w);
    logic [29:0] prod;
    logic [17:0] sum;
    prod = {17'd0, c} * {13'd0, w} + 30'd2048;
    sum  = {1'b0, acc} + prod[29:12];
    add_sat = (sum > {1'b0, ONE_Q16}) ? ONE_Q16 : sum[16:0];
  endfunction

  function automatic logic [7:0] to_byte(input logic [16:0] acc);
    logic [24:0] t;
    t = {8'd0, acc} * 25'd255 + 25'd32768;
    to_byte = (t[24:16] > 9'd255) ? 8'd255 : t[23:16];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rfbc_front.sv =====
// ----------------------------------------------------------------------------
// rfbc_front
// Classifies an incoming item and turns a sample value into a table slot.
// ----------------------------------------------------------------------------
`default_nettype none

module rfbc_front #(
  parameter int NUM_ENTRIES = 256
) (
  input  rfbc_pkg::in_item_t item_i,
  input  logic [15:0]        scale_i,
  output rfbc_pkg::q_item_t  item_o
);

  logic [38:0]               prod;
  logic [18:0]               idx_raw;
  logic [rfbc_pkg::ADDR_W-1:0] slot;

  // index = floor(value * scale) with the Q12.12 * Q8.8 product taken >> 20
  assign prod    = {16'd0, item_i.sample_value[22:0]} * {23'd0, scale_i};
  assign idx_raw = prod[38:20];

  always_comb begin
    if (item_i.sample_value[23]) begin
      slot = '0;
    end else if (idx_raw >= 19'(NUM_ENTRIES)) begin
      slot = rfbc_pkg::ADDR_W'(NUM_ENTRIES - 1);
    end else begin
      slot = idx_raw[rfbc_pkg::ADDR_W-1:0];
    end
  end

  always_comb begin
    item_o.rgba.r = rfbc_pkg::sat_q12(item_i.table_red);
    item_o.rgba.g = rfbc_pkg::sat_q12(item_i.table_green);
    item_o.rgba.b = rfbc_pkg::sat_q12(item_i.table_blue);
    item_o.rgba.a = rfbc_pkg::sat_q12(item_i.table_opacity);
    if (item_i.command == rfbc_pkg::CMD_LOAD) begin
      // out-of-range loads are dropped
      item_o.op   = (32'(item_i.table_index) < NUM_ENTRIES) ? rfbc_pkg::OP_LOAD
                                                            : rfbc_pkg::OP_NOP;
      item_o.addr = rfbc_pkg::ADDR_W'(item_i.table_index);
      item_o.last = 1'b0;
    end else begin
      item_o.op   = item_i.sample_inside ? rfbc_pkg::OP_SHADE : rfbc_pkg::OP_SKIP;
      item_o.addr = slot;
      item_o.last = item_i.last_sample;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rfbc_queue.sv =====
// ----------------------------------------------------------------------------
// rfbc_queue
// Small FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module rfbc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rfbc_pkg::q_item_t item_i,
  output logic              full_o,
  output logic              valid_o,
  output rfbc_pkg::q_item_t item_o,
  input  logic              pop_i
);

  rfbc_pkg::q_item_t slots_q [rfbc_pkg::QUEUE_DEPTH];

  logic [rfbc_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [rfbc_pkg::QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [rfbc_pkg::QPTR_W:0]   count_q, count_d;

  assign full_o  = (count_q == (rfbc_pkg::QPTR_W+1)'(rfbc_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + {{rfbc_pkg::QPTR_W{1'b0}}, push_i}
                       - {{rfbc_pkg::QPTR_W{1'b0}}, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rfbc_back.sv =====
// ----------------------------------------------------------------------------
// rfbc_back
// Transfer table and compositing sequencer; owns the pixel output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rfbc_back #(
  parameter int NUM_ENTRIES = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  rfbc_pkg::q_item_t   q_item_i,
  output logic                q_pop_o,
  input  logic [12:0]         floor_i,
  input  logic [16:0]         term_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rfbc_pkg::out_item_t out_item_o
);

  localparam int IDX_W = $clog2(NUM_ENTRIES);

  rfbc_pkg::tf_entry_t table_mem [NUM_ENTRIES];
  rfbc_pkg::tf_entry_t rd_q;

  rfbc_pkg::bk_state_e state_q, state_d;

  logic [16:0] acc_r_q, acc_r_d;
  logic [16:0] acc_g_q, acc_g_d;
  logic [16:0] acc_b_q, acc_b_d;
  logic [16:0] acc_a_q, acc_a_d;
  logic        done_q, done_d;
  logic        last_q, last_d;
  logic [16:0] w_q, w_d;
  logic        out_valid_q, out_valid_d;
  rfbc_pkg::out_item_t out_q, out_d;

  logic        mem_we, mem_re;
  logic [17:0] alpha_sum;
  logic [16:0] alpha_new;

  assign alpha_sum = {1'b0, acc_a_q} + {1'b0, w_q};
  assign alpha_new = (alpha_sum > {1'b0, rfbc_pkg::ONE_Q16}) ? rfbc_pkg::ONE_Q16
                                                             : alpha_sum[16:0];

  always_comb begin
    state_d     = state_q;
    acc_r_d     = acc_r_q;
    acc_g_d     = acc_g_q;
    acc_b_d     = acc_b_q;
    acc_a_d     = acc_a_q;
    done_d      = done_q;
    last_d      = last_q;
    w_d         = w_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_d       = out_q;
    q_pop_o     = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;

    case (state_q)
      rfbc_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          last_d  = q_item_i.last;
          if (q_item_i.op == rfbc_pkg::OP_LOAD) begin
            mem_we = 1'b1;
          end else if (q_item_i.op == rfbc_pkg::OP_SHADE && !done_q) begin
            mem_re  = 1'b1;
            state_d = rfbc_pkg::BK_LOOKUP;
          end else if (q_item_i.last) begin
            // skipped sample or finished ray closing the pixel
            state_d = rfbc_pkg::BK_EMIT;
          end
        end
      end
      rfbc_pkg::BK_LOOKUP: begin
        // faint entries contribute a zero weight
        w_d     = (rd_q.a > floor_i) ? rfbc_pkg::blend_weight(rd_q.a, acc_a_q) : '0;
        state_d = rfbc_pkg::BK_BLEND;
      end
      rfbc_pkg::BK_BLEND: begin
        acc_r_d = rfbc_pkg::add_sat(acc_r_q, rd_q.r, w_q);
        acc_g_d = rfbc_pkg::add_sat(acc_g_q, rd_q.g, w_q);
        acc_b_d = rfbc_pkg::add_sat(acc_b_q, rd_q.b, w_q);
        acc_a_d = alpha_new;
        done_d  = (alpha_new >= term_i);
        state_d = last_q ? rfbc_pkg::BK_EMIT : rfbc_pkg::BK_IDLE;
      end
      rfbc_pkg::BK_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d         = 1'b1;
          out_d.pixel_red     = rfbc_pkg::to_byte(acc_r_q);
          out_d.pixel_green   = rfbc_pkg::to_byte(acc_g_q);
          out_d.pixel_blue    = rfbc_pkg::to_byte(acc_b_q);
          out_d.pixel_alpha   = 8'd255;
          out_d.stopped_early = done_q;
          acc_r_d = '0;
          acc_g_d = '0;
          acc_b_d = '0;
          acc_a_d = '0;
          done_d  = 1'b0;
          state_d = rfbc_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = rfbc_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rfbc_pkg::BK_IDLE;
      acc_r_q     <= '0;
      acc_g_q     <= '0;
      acc_b_q     <= '0;
      acc_a_q     <= '0;
      done_q      <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_r_q     <= acc_r_d;
      acc_g_q     <= acc_g_d;
      acc_b_q     <= acc_b_d;
      acc_a_q     <= acc_a_d;
      done_q      <= done_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q   <= w_d;
    out_q <= out_d;
  end

  // transfer table: one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[q_item_i.addr[IDX_W-1:0]] <= q_item_i.rgba;
    end
    if (mem_re) begin
      rd_q <= table_mem[q_item_i.addr[IDX_W-1:0]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/ray_front_to_back_compositor.sv =====
// ----------------------------------------------------------------------------
// ray_front_to_back_compositor
// Front-to-back alpha compositing of one ray's samples into an RGBA pixel.
// ----------------------------------------------------------------------------
// Items are either table loads (write one RGBA entry of the transfer table) or
// ray samples. The front classifies each item and scales a sample value into
// a clamped table slot; it accepts one item per cycle as long as the 4-entry
// queue has room. The back drains the queue: a load, an outside sample, a
// sample after termination or a dropped load is handled in the idle state; a
// shaded inside sample goes through table read, weight multiply and color
// blend, bounded by the accumulated-alpha feedback loop through the weight
// multiply, and the back takes no new item until the blend is done. A
// last-of-ray sample then passes through the emit state to form the pixel
// into the output register, and waits in that state while the previous
// pixel has not been taken. Pixels come out as rounded, saturated bytes with
// alpha 255; stopped_early flags rays that hit the termination threshold.
// Table contents come up undefined after reset; load every entry a ray can
// hit before sampling. Config writes are only legal while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_front_to_back_compositor #(
  parameter int NUM_ENTRIES = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rfbc_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rfbc_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [16:0]         cfg_wdata_i
);

  // config registers
  logic [15:0] scale_q;
  logic [12:0] floor_q;
  logic [16:0] term_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= rfbc_pkg::SCALE_RST;
      floor_q <= rfbc_pkg::FLOOR_RST;
      term_q  <= rfbc_pkg::TERM_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rfbc_pkg::CFG_SCALE: scale_q <= cfg_wdata_i[15:0];
        rfbc_pkg::CFG_FLOOR: floor_q <= cfg_wdata_i[12:0];
        rfbc_pkg::CFG_TERM:  term_q  <= cfg_wdata_i;
        default: begin
          // unmapped index: write dropped
        end
      endcase
    end
  end

  rfbc_pkg::q_item_t front_item;
  rfbc_pkg::q_item_t head_item;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  logic              push;

  assign in_ready_o = ~q_full;
  assign push       = in_valid_i & in_ready_o;

  // front: classify and compute table slot
  rfbc_front #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_front (
    .item_i  (in_item_i),
    .scale_i (scale_q),
    .item_o  (front_item)
  );

  // decoupling queue
  rfbc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (head_item),
    .pop_i   (q_pop)
  );

  // back: table, blend loop, pixel output
  rfbc_back #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (head_item),
    .q_pop_o     (q_pop),
    .floor_i     (floor_q),
    .term_i      (term_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ===== rtl/rfbc_checker.sv =====
// ----------------------------------------------------------------------------
// rfbc_checker
// Port-level properties of the compositor, bound onto the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ray_front_to_back_compositor_defines.svh"

module rfbc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input rfbc_pkg::out_item_t out_item_o,
  input logic                cfg_we_i
);

  // a waiting pixel holds
  `RFBC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o))

  // pixel alpha is always forced to opaque
  `RFBC_ASSERT_NOW(a_alpha_opaque, clk_i, rst_ni, out_valid_o, out_item_o.pixel_alpha == 8'd255)

  // leaving reset: queue empty, no pixel pending
  `RFBC_ASSERT_NOW(a_reset_clean, clk_i, rst_ni, $rose(rst_ni), in_ready_o && !out_valid_o)

  // a config write never disturbs a pending pixel
  `RFBC_ASSERT_NEXT(a_cfg_no_touch, clk_i, rst_ni, cfg_we_i && out_valid_o && !out_ready_i, $stable(out_item_o))

endmodule

bind ray_front_to_back_compositor rfbc_checker u_rfbc_checker (.*);

`default_nettype wire

// ===== tb/tb_ray_front_to_back_compositor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ray_front_to_back_compositor
// Self-checking bench: a built-in compositor predictor tracks the transfer
// table, the ray accumulators and the three config registers, and every
// pixel that leaves the block is compared field by field with the oldest
// predicted pixel. Directed rays hit the table-range, floor and termination
// corners; random rays follow across several register settings.
// ----------------------------------------------------------------------------

module tb_ray_front_to_back_compositor;
  import rfbc_pkg::*;

  localparam int TBL_DEPTH     = 256;
  localparam int SETTLE_CYCLES = 40;     // queue of 4 through the back states, plus pixel reg
  localparam int HOLD_CYCLES   = 400;    // long back-pressure stretch on the pixel side
  localparam int CYCLE_LIMIT   = 100000;
  localparam int MAX_PRINTS    = 40;

  // --------------------------------------------------------------------------
  // DUT ports; all inputs driven to known values from time zero
  // --------------------------------------------------------------------------
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_item_t    in_item_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_item_o;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_idx_i   = '0;
  logic [16:0] cfg_wdata_i = '0;

  ray_front_to_back_compositor #(
    .NUM_ENTRIES(TBL_DEPTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: shadow table, accumulators (Q1.16), live register copies
  // --------------------------------------------------------------------------
  tf_entry_t   tf_shadow [TBL_DEPTH];
  int unsigned acc_r = 0, acc_g = 0, acc_b = 0, acc_a = 0;
  logic        ray_stopped = 1'b0;
  logic [15:0] scale_q = SCALE_RST;
  logic [12:0] floor_q = FLOOR_RST;
  logic [16:0] term_q  = TERM_RST;

  // Stimulus side. slot_loaded tracks which table entries have been written
  // so far, in issue order; an inside sample never points at an empty entry.
  logic [TBL_DEPTH-1:0] slot_loaded = '0;
  in_item_t    item_pending_q [$];
  out_item_t   pixel_expect_q [$];
  int unsigned items_issued = 0;
  int unsigned items_taken  = 0;
  int unsigned pixel_cnt    = 0;
  int unsigned err_cnt      = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned stall_left   = 0;
  bit          in_sent      = 1'b0;   // set at the edge that takes an item
  bit          steady       = 1'b0;   // no random idling on either side
  bit          stall_req    = 1'b0;   // ask the pixel side for one long hold-off

  // --------------------------------------------------------------------------
  // Fixed-point helpers of the predictor
  // --------------------------------------------------------------------------
  function automatic logic [12:0] clamp_q12(logic [12:0] c);
    return (c > ONE_Q12) ? ONE_Q12 : c;
  endfunction

  // acc + round(c * w), capped at 1.0
  function automatic int unsigned blend_acc(int unsigned acc, logic [12:0] c,
                                            longint unsigned w);
    longint unsigned cw, s;
    cw = c;
    s  = acc + ((cw * w + 2048) >> 12);
    return (s > ONE_Q16) ? ONE_Q16 : int'(s);
  endfunction

  function automatic logic [7:0] pixel_byte(int unsigned acc);
    longint unsigned v;
    v = acc;
    v = (v * 255 + 32768) >> 16;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // Q12.12 value -> table entry under the current scale; negatives go to 0,
  // anything past the end is pinned to the last entry.
  function automatic int unsigned value_slot(logic [23:0] v);
    longint unsigned idx;
    if (v[23]) return 0;
    idx = v;
    idx = (idx * scale_q) >> 20;
    return (idx >= TBL_DEPTH) ? TBL_DEPTH - 1 : int'(idx);
  endfunction

  // A value landing in the given entry, jittered inside the entry's span.
  // Entries the scale cannot reach fall back to a negative value (entry 0).
  function automatic logic [23:0] value_for_slot(int unsigned slot);
    longint unsigned lo, v;
    if (scale_q != 0) begin
      lo = ((longint'(slot) << 20) + scale_q - 1) / scale_q;
      if (lo <= 24'h7FFFFF) begin
        v = lo + $urandom_range(0, (1 << 20) / scale_q);
        if (v > 24'h7FFFFF || value_slot(v[23:0]) != slot) v = lo;
        return v[23:0];
      end
    end
    return {1'b1, 23'($urandom)};
  endfunction

  // One accepted item through the compositor: table write, or blend/emit.
  task automatic compose_step(in_item_t it);
    tf_entry_t       e;
    longint unsigned w, inv;
    out_item_t       px;
    if (it.command == CMD_LOAD) begin
      tf_shadow[it.table_index] = '{r: clamp_q12(it.table_red),
                                    g: clamp_q12(it.table_green),
                                    b: clamp_q12(it.table_blue),
                                    a: clamp_q12(it.table_opacity)};
    end else begin
      if (!ray_stopped && it.sample_inside) begin
        e = tf_shadow[value_slot(it.sample_value)];
        if (e.a > floor_q) begin
          inv   = ONE_Q16 - acc_a;
          w     = (inv * e.a + 2048) >> 12;
          acc_r = blend_acc(acc_r, e.r, w);
          acc_g = blend_acc(acc_g, e.g, w);
          acc_b = blend_acc(acc_b, e.b, w);
          acc_a = (acc_a + w > ONE_Q16) ? ONE_Q16 : int'(acc_a + w);
        end
        // termination is only tested on inside samples
        if (acc_a >= term_q) ray_stopped = 1'b1;
      end
      if (it.last_sample) begin
        px.pixel_red     = pixel_byte(acc_r);
        px.pixel_green   = pixel_byte(acc_g);
        px.pixel_blue    = pixel_byte(acc_b);
        px.pixel_alpha   = 8'd255;
        px.stopped_early = ray_stopped;
        pixel_expect_q.push_back(px);
        acc_r       = 0;
        acc_g       = 0;
        acc_b       = 0;
        acc_a       = 0;
        ray_stopped = 1'b0;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_error(string msg);
    if (err_cnt < MAX_PRINTS) $display("%0t ERROR %s", $time, msg);
    err_cnt++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_error($sformatf("pixel %0d %s: got %0d expected %0d",
                             pixel_cnt, name, got, want));
  endtask

  task automatic check_pixel(out_item_t got);
    out_item_t want;
    if (pixel_expect_q.size() == 0) begin
      report_error($sformatf("pixel %0d arrived with none outstanding", pixel_cnt));
    end else begin
      want = pixel_expect_q.pop_front();
      check_field("red",   got.pixel_red,     want.pixel_red);
      check_field("green", got.pixel_green,   want.pixel_green);
      check_field("blue",  got.pixel_blue,    want.pixel_blue);
      check_field("alpha", got.pixel_alpha,   want.pixel_alpha);
      check_field("stop",  {7'd0, got.stopped_early}, {7'd0, want.stopped_early});
    end
    pixel_cnt++;
  endtask

  // --------------------------------------------------------------------------
  // Item builders. Fields a command does not use are filled at random so every
  // bit of the input struct toggles.
  // --------------------------------------------------------------------------
  task automatic push_load(logic [7:0] idx, logic [12:0] r, logic [12:0] g,
                           logic [12:0] b, logic [12:0] a, logic last);
    in_item_t it;
    it.command       = CMD_LOAD;
    it.table_index   = idx;
    it.table_red     = r;
    it.table_green   = g;
    it.table_blue    = b;
    it.table_opacity = a;
    it.sample_inside = 1'($urandom);
    it.sample_value  = 24'($urandom);
    it.last_sample   = last;
    item_pending_q.push_back(it);
    items_issued++;
    slot_loaded[idx] = 1'b1;
  endtask

  task automatic push_sample(logic in_vol, logic [23:0] v, logic last);
    in_item_t it;
    // keep inside samples on written entries; entry 0 is always written
    if (in_vol && !slot_loaded[value_slot(v)]) v[23] = 1'b1;
    it.command       = CMD_SAMPLE;
    it.table_index   = 8'($urandom);
    it.table_red     = 13'($urandom);
    it.table_green   = 13'($urandom);
    it.table_blue    = 13'($urandom);
    it.table_opacity = 13'($urandom);
    it.sample_inside = in_vol;
    it.sample_value  = v;
    it.last_sample   = last;
    item_pending_q.push_back(it);
    items_issued++;
  endtask

  // component mix: full scale, zero, above one (saturates), in range
  function automatic logic [12:0] rand_comp();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 10) return ONE_Q12;
    if (p < 20) return 13'd0;
    if (p < 35) return 13'($urandom_range(4097, 8191));
    return 13'($urandom_range(0, 4096));
  endfunction

  // Random rays (about 6 samples each) with table loads mixed in; the batch
  // always ends on a closing sample so no ray spans a register change.
  task automatic random_items(int n, int load_pct);
    int unsigned pick, slot;
    logic [23:0] v;
    repeat (n) begin
      if ($urandom_range(0, 99) < load_pct) begin
        push_load(8'($urandom_range(0, TBL_DEPTH - 1)), rand_comp(), rand_comp(),
                  rand_comp(), rand_comp(), 1'($urandom));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          slot = $urandom_range(0, TBL_DEPTH - 1);
          if (!slot_loaded[slot]) slot = $urandom_range(0, TBL_DEPTH - 1);
          v = value_for_slot(slot);
        end else if (pick < 75) begin
          v = 24'($urandom);
        end else if (pick < 90) begin
          v = 24'($urandom_range(0, 65535));
        end else begin
          v = {1'b1, 23'($urandom)};
        end
        push_sample($urandom_range(0, 99) < 85, v, $urandom_range(0, 5) == 0);
      end
    end
    push_sample(1'b0, 24'($urandom), 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Config writes, only with the block drained
  // --------------------------------------------------------------------------
  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_SCALE: scale_q = val[15:0];
      CFG_FLOOR: floor_q = val[12:0];
      CFG_TERM:  term_q  = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_phase(logic [15:0] scale, logic [12:0] flr, logic [16:0] term);
    write_reg(CFG_SCALE, {1'b0, scale});
    write_reg(CFG_FLOOR, {4'b0, flr});
    write_reg(CFG_TERM, term);
  endtask

  // Every issued item taken and every pixel seen, then let trailing loads
  // and skipped samples work through the back end.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (items_taken != items_issued || pixel_expect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Input driver: new item at the falling edge once the previous one is taken
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_sent) begin
      in_sent = 1'b0;
      if (item_pending_q.size() != 0 && (steady || $urandom_range(0, 99) >= 20)) begin
        in_item_i  <= item_pending_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Pixel-side ready: random stalls, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (stall_req) begin
      stall_req  = 1'b0;
      stall_left = HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= steady || ($urandom_range(0, 99) >= 20);
    end
  end

  // Monitor: check the pixel first, then run the accepted item through the
  // predictor, so ordering within the edge is fixed.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) check_pixel(out_item_o);
      if (in_valid_i && in_ready_o) begin
        in_sent = 1'b1;
        items_taken++;
        compose_step(in_item_i);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL ray_front_to_back_compositor");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: table corners, floor, range clamps, termination
    push_load(8'd0, 13'd0, ONE_Q12, 13'h1FFF, 13'd2048, 1'b0);  // blue saturates
    push_load(8'd255, ONE_Q12, ONE_Q12, ONE_Q12, ONE_Q12, 1'b0);
    push_load(8'd128, 13'd1000, 13'd2000, 13'd3000, 13'd1, 1'b1); // opacity at floor, last ignored
    push_sample(1'b0, 24'($urandom), 1'b0);          // outside: no effect
    push_sample(1'b1, 24'h800000, 1'b0);             // most negative -> entry 0
    push_sample(1'b1, value_for_slot(128), 1'b0);    // at the floor -> skipped
    push_sample(1'b1, 24'h7FFFFF, 1'b0);             // past the end -> last entry, opaque
    push_sample(1'b1, {1'b1, 23'($urandom)}, 1'b0);  // ray already stopped
    push_sample(1'b0, 24'($urandom), 1'b1);          // pixel with stop flag
    push_sample(1'b1, 24'd0, 1'b1);                  // single-sample ray
    push_sample(1'b0, 24'($urandom), 1'b1);          // empty ray
    random_items(350, 20);
    wait_idle();

    // zero scale, zero floor, zero threshold: first inside sample ends the ray
    set_phase(16'd0, 13'd0, 17'd0);
    @(posedge clk_i);
    push_sample(1'b0, 24'($urandom), 1'b0);
    push_sample(1'b0, 24'($urandom), 1'b1);          // outside only: never stopped
    push_load(8'd0, ONE_Q12, 13'd0, 13'd0, 13'd0, 1'b0);
    push_sample(1'b1, 24'($urandom_range(0, 24'h7FFFFF)), 1'b0); // clear entry, still stops
    push_sample(1'b1, 24'hFFFFFF, 1'b1);
    random_items(120, 10);
    wait_idle();

    // top scale, threshold never below full alpha; pixel side holds off long
    set_phase(16'hFFFF, 13'd0, ONE_Q16);
    @(posedge clk_i);
    stall_req = 1'b1;
    random_items(200, 10);
    wait_idle();

    // floor at one: nothing contributes
    set_phase(16'($urandom_range(1, 65535)), ONE_Q12, 17'($urandom_range(0, 65536)));
    @(posedge clk_i);
    random_items(100, 15);
    wait_idle();

    // mid settings, both sides without idling
    set_phase(16'($urandom_range(2000, 12000)), 13'($urandom_range(0, 300)),
              17'($urandom_range(40000, 65536)));
    @(posedge clk_i);
    steady = 1'b1;
    random_items(300, 10);
    wait_idle();

    if (err_cnt == 0) begin
      $display("PASS ray_front_to_back_compositor");
    end else begin
      $display("FAIL ray_front_to_back_compositor");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rfbc_pkg.sv
rtl/rfbc_front.sv
rtl/rfbc_queue.sv
rtl/rfbc_back.sv
rtl/ray_front_to_back_compositor.sv
rtl/rfbc_checker.sv
tb/tb_ray_front_to_back_compositor.sv
